// ===== rtl/mna_matrix_stamper_defines.svh =====
// Assertion macros for mna_matrix_stamper.sv, the file that carries the concurrent checks.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef MNA_MATRIX_STAMPER_DEFINES_SVH
`define MNA_MATRIX_STAMPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mna_pkg.sv =====
package mna_pkg;

  // Operation codes.
  localparam logic [1:0] OP_STAMP = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Element kinds.
  localparam logic [2:0] EK_RES  = 3'd0;
  localparam logic [2:0] EK_CAP  = 3'd1;
  localparam logic [2:0] EK_ISRC = 3'd2;
  localparam logic [2:0] EK_VSRC = 3'd3;
  localparam logic [2:0] EK_IND  = 3'd4;

  // Store selection.
  localparam logic [1:0] SS_G = 2'd0;
  localparam logic [1:0] SS_C = 2'd1;
  localparam logic [1:0] SS_B = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ROWS = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIENT  = 2'd1;

  // Accumulation step sequencing.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

  // Reciprocal divider: 33 quotient bits, one a cycle.
  localparam logic [5:0] DIV_LAST = 6'd32;

  localparam logic [6:0] ROW_LIMIT = 7'd127;

  localparam logic signed [33:0] Q_ONE   = 34'sd65536;
  localparam logic signed [33:0] SUM_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SUM_MIN = 34'sh3_8000_0000;

  typedef struct packed {
    logic              latch;
    logic              div_step;
    logic              div_fin;
    logic              acc_wr;
    logic              read_cap;
    logic              clr_step;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       is_res;
    logic       step_en;
    logic       div_last;
    logic       clr_last;
  } dp_stat_t;

endpackage

// ===== rtl/mna_ram.sv =====
module mna_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mna_ctrl.sv =====
module mna_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mna_pkg::dp_stat_t  stat,
  output mna_pkg::ctrl_cmd_t cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_CLEAR    = 10'b00_0000_0100,
    S_DIV      = 10'b00_0000_1000,
    S_DIVFIN   = 10'b00_0001_0000,
    S_ISSUE    = 10'b00_0010_0000,
    S_WRITE    = 10'b00_0100_0000,
    S_READ     = 10'b00_1000_0000,
    S_READW    = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t                     state, state_next;
  logic [mna_pkg::STEP_W-1:0] step, step_next;
  logic                       clr_op, clr_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      // The store clearing pass runs straight out of reset.
      state  <= S_CLEAR;
      step   <= '0;
      clr_op <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      clr_op <= clr_op_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    clr_op_next  = clr_op;
    cmd          = '0;
    cmd.step     = step;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        step_next = '0;
        case (stat.op)
          mna_pkg::OP_STAMP: state_next = stat.is_res ? S_DIV : S_ISSUE;
          mna_pkg::OP_READ:  state_next = S_READ;
          mna_pkg::OP_CLEAR: begin
            clr_op_next = 1'b1;
            state_next  = S_CLEAR;
          end
          default:           state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          clr_op_next = 1'b0;
          state_next  = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DIVFIN;
        end
      end
      S_DIVFIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_ISSUE;
      end
      S_ISSUE: begin
        if (stat.step_en) begin
          state_next = S_WRITE;
        end else if (step == mna_pkg::STEP_LAST) begin
          state_next = S_DONE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_WRITE: begin
        cmd.acc_wr = 1'b1;
        if (step == mna_pkg::STEP_LAST) begin
          state_next = S_DONE;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_READ:  state_next = S_READW;
      S_READW: begin
        cmd.read_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== rtl/mna_dp.sv =====
module mna_dp #(
  parameter int MATRIX_DIM = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mna_pkg::ctrl_cmd_t                 cmd,
  output mna_pkg::dp_stat_t                  stat,
  input  logic                               cfg_we,
  input  logic [mna_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mna_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                         opcode,
  input  logic [2:0]                         element_kind,
  input  logic [5:0]                         node_plus,
  input  logic [5:0]                         node_minus,
  input  logic signed [31:0]                 element_value,
  input  logic [1:0]                         store_select,
  input  logic [5:0]                         read_row,
  input  logic [5:0]                         read_col,
  output logic signed [31:0]                 read_value,
  output logic [5:0]                         branch_row,
  output logic [1:0]                         status
);

  localparam int MAT_DEPTH = MATRIX_DIM * MATRIX_DIM;
  localparam int IW        = $clog2(MATRIX_DIM);
  localparam int AW        = $clog2(MAT_DEPTH);

  // Configuration registers.
  logic [5:0] node_count;
  logic       transient_mode;
  logic [6:0] extra_rows_used;

  // Latched item.
  logic [1:0]         op_q;
  logic [2:0]         kind_q;
  logic signed [31:0] val_q;
  logic               hp_q, hm_q, row_ok_q, read_ok_q;
  logic [IW-1:0]      p_q, m_q, k_q, rrow_q, rcol_q;
  logic [1:0]         rsel_q;

  // Reciprocal divider.
  logic [5:0]         div_cnt;
  logic [31:0]        div_rem;
  logic [32:0]        div_q;
  logic signed [31:0] cond;

  // Data of the selected store.
  logic signed [31:0] rd_sel_data;

  // Clearing pass.
  logic [AW-1:0] clr_addr;

  // Item decode at the start handshake.
  logic [5:0] np, nm;
  logic [7:0] k_sum;
  logic       row_ok;

  assign np    = node_plus - 6'd1;
  assign nm    = node_minus - 6'd1;
  assign k_sum = 8'(node_count) + 8'(extra_rows_used);
  assign row_ok = (32'(k_sum) < MATRIX_DIM) && (extra_rows_used != mna_pkg::ROW_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= '0;
      transient_mode  <= 1'b0;
      extra_rows_used <= '0;
      clr_addr        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mna_pkg::CFG_NODE_COUNT: node_count     <= cfg_data[5:0];
          mna_pkg::CFG_TRANSIENT:  transient_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.latch) begin
        if (opcode == mna_pkg::OP_CLEAR) begin
          extra_rows_used <= '0;
        end else if (opcode == mna_pkg::OP_STAMP && row_ok &&
                     (element_kind == mna_pkg::EK_VSRC ||
                      element_kind == mna_pkg::EK_IND)) begin
          extra_rows_used <= extra_rows_used + 7'd1;
        end
      end
      if (cmd.clr_step) begin
        clr_addr <= (clr_addr == AW'(MAT_DEPTH - 1)) ? '0 : clr_addr + 1'b1;
      end
    end
  end

  // Divisor magnitude and one restoring step.
  logic [31:0] div_mag;
  logic [32:0] div_shift;
  logic        div_ge;

  assign div_mag   = val_q[31] ? (~val_q + 32'd1) : val_q;
  assign div_shift = {div_rem, (div_cnt == 6'd0)};
  assign div_ge    = div_shift >= {1'b0, div_mag};

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q      <= opcode;
      kind_q    <= element_kind;
      val_q     <= element_value;
      hp_q      <= (node_plus != 6'd0) && (32'(np) < MATRIX_DIM);
      hm_q      <= (node_minus != 6'd0) && (32'(nm) < MATRIX_DIM);
      p_q       <= IW'(np);
      m_q       <= IW'(nm);
      k_q       <= IW'(k_sum);
      row_ok_q  <= row_ok;
      rsel_q    <= store_select;
      rrow_q    <= IW'(read_row);
      rcol_q    <= IW'(read_col);
      read_ok_q <= (32'(read_row) < MATRIX_DIM) &&
                   ((store_select == mna_pkg::SS_B) ||
                    ((store_select == mna_pkg::SS_G || store_select == mna_pkg::SS_C) &&
                     (32'(read_col) < MATRIX_DIM)));
      div_cnt   <= '0;
      div_rem   <= '0;
      div_q     <= '0;
      read_value <= '0;
      if (opcode == mna_pkg::OP_STAMP &&
          (element_kind == mna_pkg::EK_VSRC || element_kind == mna_pkg::EK_IND)) begin
        if (row_ok) begin
          branch_row <= k_sum[5:0];
          status     <= mna_pkg::ST_OK;
        end else begin
          branch_row <= '0;
          status     <= mna_pkg::ST_ROWS;
        end
      end else begin
        branch_row <= '0;
        status     <= mna_pkg::ST_OK;
      end
    end
    if (cmd.div_step) begin
      div_rem <= div_ge ? 32'(div_shift - {1'b0, div_mag}) : div_shift[31:0];
      div_q   <= {div_q[31:0], div_ge};
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.div_fin) begin
      // Sign and clamp the quotient magnitude; a zero divisor saturates.
      if (!val_q[31]) begin
        if (div_q > 33'h0_7FFF_FFFF) begin
          cond   <= 32'sh7FFF_FFFF;
          status <= mna_pkg::ST_SAT;
        end else begin
          cond <= div_q[31:0];
        end
      end else begin
        if (div_q > 33'h0_8000_0000) begin
          cond   <= 32'sh8000_0000;
          status <= mna_pkg::ST_SAT;
        end else begin
          cond <= ~div_q[31:0] + 32'd1;
        end
      end
    end
    if (cmd.read_cap) begin
      read_value <= read_ok_q ? rd_sel_data : '0;
    end
  end

  // Access descriptor for the current step.
  logic [1:0]         acc_sel;
  logic [IW-1:0]      acc_row, acc_col;
  logic signed [33:0] acc_delta, base_d, val34;
  logic               acc_en;

  assign val34  = 34'(val_q);
  assign base_d = (kind_q == mna_pkg::EK_RES) ? 34'(cond) : val34;

  always_comb begin
    acc_sel   = mna_pkg::SS_G;
    acc_row   = p_q;
    acc_col   = p_q;
    acc_delta = base_d;
    acc_en    = 1'b0;
    case (kind_q)
      mna_pkg::EK_RES, mna_pkg::EK_CAP: begin
        acc_sel = (kind_q == mna_pkg::EK_RES) ? mna_pkg::SS_G : mna_pkg::SS_C;
        case (cmd.step)
          3'd0: acc_en = hp_q;
          3'd1: begin
            acc_col   = m_q;
            acc_delta = -base_d;
            acc_en    = hp_q && hm_q;
          end
          3'd2: begin
            acc_row   = m_q;
            acc_delta = -base_d;
            acc_en    = hp_q && hm_q;
          end
          3'd3: begin
            acc_row = m_q;
            acc_col = m_q;
            acc_en  = hm_q;
          end
          default: acc_en = 1'b0;
        endcase
        if (kind_q == mna_pkg::EK_CAP && !transient_mode) begin
          acc_en = 1'b0;
        end
      end
      mna_pkg::EK_ISRC: begin
        acc_sel = mna_pkg::SS_B;
        case (cmd.step)
          3'd0: begin
            acc_delta = -val34;
            acc_en    = hp_q;
          end
          3'd1: begin
            acc_row   = m_q;
            acc_delta = val34;
            acc_en    = hm_q;
          end
          default: acc_en = 1'b0;
        endcase
      end
      mna_pkg::EK_VSRC, mna_pkg::EK_IND: begin
        case (cmd.step)
          3'd0: begin
            acc_row   = k_q;
            acc_delta = mna_pkg::Q_ONE;
            acc_en    = hp_q;
          end
          3'd1: begin
            acc_col   = k_q;
            acc_delta = mna_pkg::Q_ONE;
            acc_en    = hp_q;
          end
          3'd2: begin
            acc_row   = k_q;
            acc_col   = m_q;
            acc_delta = -mna_pkg::Q_ONE;
            acc_en    = hm_q;
          end
          3'd3: begin
            acc_row   = m_q;
            acc_col   = k_q;
            acc_delta = -mna_pkg::Q_ONE;
            acc_en    = hm_q;
          end
          3'd4: begin
            acc_row = k_q;
            acc_col = k_q;
            if (kind_q == mna_pkg::EK_VSRC) begin
              acc_sel   = mna_pkg::SS_B;
              acc_delta = val34;
              acc_en    = 1'b1;
            end else begin
              acc_sel   = mna_pkg::SS_C;
              acc_delta = -val34;
              acc_en    = transient_mode;
            end
          end
          default: acc_en = 1'b0;
        endcase
        if (!row_ok_q) begin
          acc_en = 1'b0;
        end
      end
      default: acc_en = 1'b0;
    endcase
  end

  // Store addressing: a read operation uses its own row and column.
  logic [IW-1:0]      mrow, mcol;
  logic [1:0]         cur_sel;
  logic [AW-1:0]      maddr, g_waddr;
  logic [IW-1:0]      b_waddr;
  logic [31:0]        g_rdata, c_rdata, b_rdata, wzero;
  logic signed [33:0] sum;
  logic signed [31:0] sum_sat;
  logic               g_we, c_we, b_we;

  assign mrow    = (op_q == mna_pkg::OP_READ) ? rrow_q : acc_row;
  assign mcol    = (op_q == mna_pkg::OP_READ) ? rcol_q : acc_col;
  assign cur_sel = (op_q == mna_pkg::OP_READ) ? rsel_q : acc_sel;
  assign maddr   = AW'(mrow) * AW'(MATRIX_DIM) + AW'(mcol);

  always_comb begin
    case (cur_sel)
      mna_pkg::SS_G: rd_sel_data = g_rdata;
      mna_pkg::SS_C: rd_sel_data = c_rdata;
      mna_pkg::SS_B: rd_sel_data = b_rdata;
      default:       rd_sel_data = '0;
    endcase
  end

  assign sum = 34'(rd_sel_data) + acc_delta;
  always_comb begin
    if (sum > mna_pkg::SUM_MAX) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum < mna_pkg::SUM_MIN) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  assign g_we    = cmd.clr_step || (cmd.acc_wr && acc_sel == mna_pkg::SS_G);
  assign c_we    = cmd.clr_step || (cmd.acc_wr && acc_sel == mna_pkg::SS_C);
  assign b_we    = (cmd.clr_step && (32'(clr_addr) < MATRIX_DIM)) ||
                   (cmd.acc_wr && acc_sel == mna_pkg::SS_B);
  assign g_waddr = cmd.clr_step ? clr_addr : maddr;
  assign b_waddr = cmd.clr_step ? IW'(clr_addr) : acc_row;
  assign wzero   = cmd.clr_step ? 32'd0 : sum_sat;

  mna_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_g_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(wzero),
    .raddr(maddr), .rdata(g_rdata)
  );

  mna_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(g_waddr), .wdata(wzero),
    .raddr(maddr), .rdata(c_rdata)
  );

  mna_ram #(.WIDTH(32), .DEPTH(MATRIX_DIM)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(wzero),
    .raddr(mrow), .rdata(b_rdata)
  );

  assign stat.op       = op_q;
  assign stat.is_res   = (kind_q == mna_pkg::EK_RES);
  assign stat.step_en  = acc_en;
  assign stat.div_last = (div_cnt == mna_pkg::DIV_LAST);
  assign stat.clr_last = (clr_addr == AW'(MAT_DEPTH - 1));

endmodule

// ===== rtl/mna_matrix_stamper.sv =====
// Channel   | Direction | Handshake              | Payload
// command   | in        | start, busy            | opcode .. read_col
// result    | out       | done (one-cycle strobe)| read_value, branch_row, status
// config    | in        | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A command is taken when start is high and busy is low; one item is worked at a time.
// A resistor stamp runs the bit-serial reciprocal divider, followed by up to four
// read-modify-write transfers on the conductance memory. A clear runs one pass over
// MATRIX_DIM*MATRIX_DIM addresses, and the same pass runs after reset with busy held
// high. Results are valid under done and stay stable until the next command is taken.
module mna_matrix_stamper #(
  parameter int MATRIX_DIM = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [2:0]                     element_kind,
  input  logic [5:0]                     node_plus,
  input  logic [5:0]                     node_minus,
  input  logic signed [31:0]             element_value,
  input  logic [1:0]                     store_select,
  input  logic [5:0]                     read_row,
  input  logic [5:0]                     read_col,
  output logic                           done,
  output logic signed [31:0]             read_value,
  output logic [5:0]                     branch_row,
  output logic [1:0]                     status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mna_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mna_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "mna_matrix_stamper_defines.svh"

  mna_pkg::ctrl_cmd_t cmd;
  mna_pkg::dp_stat_t  stat;

  // Configuration writes are always taken; the user must issue them only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  // The controller sequences the divider, the accumulation steps and the
  // clearing pass; it sees the datapath only through the status group.
  mna_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(done)
  );

  // The datapath holds the stores, the latched item, the divider and the
  // result registers, which stay stable until the next command is taken.
  mna_dp #(.MATRIX_DIM(MATRIX_DIM)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .opcode(opcode), .element_kind(element_kind), .node_plus(node_plus),
    .node_minus(node_minus), .element_value(element_value),
    .store_select(store_select), .read_row(read_row), .read_col(read_col),
    .read_value(read_value), .branch_row(branch_row), .status(status)
  );

  // A result strobe lasts exactly one cycle.
  `MNA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
  // A taken command makes the block busy in the next cycle.
  `MNA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command taken but block not busy")
  // A dropped branch stamp reports no branch row.
  `MNA_ASSERT_NOW(a_drop_row, done && status == mna_pkg::ST_ROWS, branch_row == 6'd0,
    "dropped stamp reported a branch row")

endmodule
